// File: sv/sed_pkg.sv
// Shared types, character constants and decode functions for the string escape decoder.
// No dependencies; the files that use it refer to it by scoped names.
package sed_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  // Depth of the queue between the classifier and the serialiser
  localparam int SED_Q_DEPTH = 2;

  // Decoded bytes caused by one input transaction (cnt is 1 to 3)
  typedef struct packed {
    logic [1:0]      cnt;
    logic            eol;
    logic [2:0][7:0] data;
  } sed_bundle_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } sed_letter_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } sed_hex_t;

  function automatic sed_letter_t letter_code(input logic [7:0] c);
    sed_letter_t r;
    r.hit  = 1'b1;
    r.code = 8'h00;
    case (c)
      8'h6E: r.code = 8'h0A; // n
      8'h74: r.code = 8'h09; // t
      8'h72: r.code = 8'h0D; // r
      8'h62: r.code = 8'h08; // b
      8'h66: r.code = 8'h0C; // f
      8'h76: r.code = 8'h0B; // v
      8'h61: r.code = 8'h07; // a
      8'h5C: r.code = 8'h5C;
      8'h22: r.code = 8'h22;
      8'h27: r.code = 8'h27;
      8'h3F: r.code = 8'h3F;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c[7:3] == 5'b00110);
  endfunction

  function automatic sed_hex_t hex_nibble(input logic [7:0] c);
    sed_hex_t r;
    r.ok  = 1'b0;
    r.nib = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.nib = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// File: sv/sed_ifs.sv
// Valid/ready channel interfaces for the raw byte input and the decoded byte output.
// No dependencies.
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_literal;

  modport source (output valid, output in_byte, output end_of_literal, input ready);
  modport sink   (input valid, input in_byte, input end_of_literal, output ready);
endinterface

interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output out_byte, output run_last, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_done,
                  output ready);
endinterface

// File: sv/sed_front.sv
// Front end: accepts raw bytes, runs the escape state machine, emits result bundles.
// Depends on sed_pkg and sed_ifs.
module sed_front (
  input  logic                clk,
  input  logic                rst_n,
  sed_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                push,
  output sed_pkg::sed_bundle_t push_data
);

  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_OCT2   = 3'd2;
  localparam logic [2:0] PH_OCT3   = 3'd3;
  localparam logic [2:0] PH_HEX1   = 3'd4;
  localparam logic [2:0] PH_HEX2   = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] pval_r, pval_nxt;
  logic [7:0] held_r, held_nxt;
  logic       acc;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign push        = acc && (push_data.cnt != 2'd0);

  always_comb begin
    logic [7:0]            b;
    logic                  eol;
    logic                  plain;
    logic                  oct;
    logic [1:0]            n;
    logic [2:0][7:0]       bq;
    sed_pkg::sed_letter_t  lc;
    sed_pkg::sed_hex_t     hx;
    b         = in_ch.in_byte;
    eol       = in_ch.end_of_literal;
    lc        = sed_pkg::letter_code(b);
    hx        = sed_pkg::hex_nibble(b);
    oct       = sed_pkg::is_oct(b);
    plain     = 1'b0;
    n         = 2'd0;
    bq        = '0;
    phase_nxt = PH_NORMAL;
    pval_nxt  = pval_r;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_ESC: begin
        if (lc.hit) begin
          bq[n] = lc.code; n = n + 2'd1;
        end else if (oct) begin
          if (eol) begin
            bq[n] = {5'd0, b[2:0]}; n = n + 2'd1;
          end else begin
            pval_nxt  = {5'd0, b[2:0]};
            phase_nxt = PH_OCT2;
          end
        end else if (b == sed_pkg::CH_X && !eol) begin
          phase_nxt = PH_HEX1;
        end else begin
          bq[n] = sed_pkg::CH_BSLASH; n = n + 2'd1;
        end
      end
      PH_OCT2: begin
        if (oct) begin
          if (eol) begin
            bq[n] = {pval_r[4:0], b[2:0]}; n = n + 2'd1;
          end else begin
            pval_nxt  = {pval_r[4:0], b[2:0]};
            held_nxt  = b;
            phase_nxt = PH_OCT3;
          end
        end else begin
          bq[n] = pval_r; n = n + 2'd1;
          plain = 1'b1;
        end
      end
      PH_OCT3: begin
        if (oct) begin
          if (pval_r[7:5] == 3'd0) begin
            bq[n] = {pval_r[4:0], b[2:0]}; n = n + 2'd1;
          end else begin
            bq[n] = sed_pkg::CH_BSLASH; n = n + 2'd1;
            bq[n] = held_r;             n = n + 2'd1;
            bq[n] = b;                  n = n + 2'd1;
          end
        end else begin
          bq[n] = pval_r; n = n + 2'd1;
          plain = 1'b1;
        end
      end
      PH_HEX1: begin
        if (hx.ok && !eol) begin
          pval_nxt  = {4'd0, hx.nib};
          held_nxt  = b;
          phase_nxt = PH_HEX2;
        end else begin
          bq[n] = sed_pkg::CH_BSLASH; n = n + 2'd1;
          plain = 1'b1;
        end
      end
      PH_HEX2: begin
        if (hx.ok) begin
          bq[n] = {pval_r[3:0], hx.nib}; n = n + 2'd1;
        end else begin
          bq[n] = sed_pkg::CH_BSLASH; n = n + 2'd1;
          bq[n] = held_r;             n = n + 2'd1;
          plain = 1'b1;
        end
      end
      default: plain = 1'b1;
    endcase
    if (plain) begin
      if (b == sed_pkg::CH_BSLASH && !eol) begin
        phase_nxt = PH_ESC;
      end else begin
        bq[n] = b; n = n + 2'd1;
      end
    end
    if (eol) begin
      phase_nxt = PH_NORMAL;
    end
    push_data.cnt  = n;
    push_data.eol  = eol;
    push_data.data = bq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      pval_r  <= 8'd0;
      held_r  <= 8'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pval_r  <= pval_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// File: sv/sed_queue.sv
// Short bundle queue between the front end and the output serialiser.
// Depends on sed_pkg.
module sed_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sed_pkg::sed_bundle_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 nonempty,
  output sed_pkg::sed_bundle_t head
);

  localparam int PW = (sed_pkg::SED_Q_DEPTH > 1) ? $clog2(sed_pkg::SED_Q_DEPTH) : 1;
  localparam int CW = $clog2(sed_pkg::SED_Q_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(sed_pkg::SED_Q_DEPTH - 1);

  sed_pkg::sed_bundle_t ent_r [sed_pkg::SED_Q_DEPTH];
  logic [PW-1:0]        wp_r, rp_r;
  logic [CW-1:0]        cnt_r;

  assign full     = (cnt_r == CW'(sed_pkg::SED_Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: sv/sed_back.sv
// Back end: when not stalled, moves one queued byte a cycle into a registered output.
// Depends on sed_pkg and sed_ifs.
module sed_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 nonempty,
  input  sed_pkg::sed_bundle_t head,
  output logic                 pop,
  sed_out_if.source            out_ch
);

  logic [1:0] idx_r;
  logic       ov_r;
  logic [7:0] byte_r;
  logic       rl_r, sd_r;
  logic       load, last;

  assign load = nonempty && (!ov_r || out_ch.ready);
  assign last = (idx_r == head.cnt - 2'd1);
  assign pop  = load && last;

  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.run_last    = rl_r;
  assign out_ch.string_done = sd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.data[idx_r];
      rl_r   <= last;
      sd_r   <= last && head.eol;
    end
  end

endmodule

// File: sv/string_escape_decoder.sv
// Decodes the body of a C string literal, one raw byte per transaction, into decoded bytes.
// The front end takes one byte a cycle while the queue is not full; the output stage sends
// one decoded byte a cycle while the receiver is ready, so bytes that expand to two or three
// results (failed hex, out-of-range or cut-short octal escapes) hold the input back once the
// two-entry queue is full. Each result is held in the queue, then in the output register.
// Bytes that open or continue an escape produce no result until the escape completes.
// Depends on sed_pkg, sed_ifs, sed_front, sed_queue and sed_back.
module string_escape_decoder (
  input  logic        clk,
  input  logic        rst_n,
  sed_in_if.sink      in_ch,
  sed_out_if.source   out_ch
);

  logic                 push, pop, full, nonempty;
  sed_pkg::sed_bundle_t push_data, head;

  sed_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (full),
    .push      (push),
    .push_data (push_data)
  );

  sed_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .nonempty  (nonempty),
    .head      (head)
  );

  sed_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for string_escape_decoder: directed table, then random literals.
// Depends on sed_pkg, sed_ifs and the decoder RTL; carries its own escape decoder predictor.
module testbench;

  typedef enum logic [2:0] {
    S_PLAIN = 3'd0,
    S_ESC   = 3'd1,
    S_OCT2  = 3'd2,
    S_OCT3  = 3'd3,
    S_HEX1  = 3'd4,
    S_HEX2  = 3'd5
  } dec_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } dec_out_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eol;
    logic       typed;
    logic [1:0] n;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
  } dir_row_t;

  localparam int N_RANDOM  = 240;
  localparam int N_DIR     = 26;
  localparam int HOLD_CYC  = 200;
  localparam int DRAIN_CYC = 10;

  localparam logic [7:0] ESC_LETTERS [11] = '{
    "n", "t", "r", "b", "f", "v", "a", 8'h5C, 8'h22, 8'h27, 8'h3F
  };

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{8'h00,              1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
    '{8'hFF,              1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00},
    '{sed_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"n",                1'b0, 1'b1, 2'd1, 8'h0A, 8'h00, 8'h00},
    '{sed_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{sed_pkg::CH_X,      1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"F",                1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"f",                1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{sed_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"4",                1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"0",                1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"0",                1'b0, 1'b1, 2'd3, 8'h5C, 8'h30, 8'h30},
    '{sed_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{sed_pkg::CH_X,      1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"g",                1'b0, 1'b1, 2'd2, 8'h5C, 8'h67, 8'h00},
    '{sed_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"u",                1'b0, 1'b1, 2'd1, 8'h5C, 8'h00, 8'h00},
    '{sed_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"1",                1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"8",                1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{sed_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"7",                1'b1, 1'b1, 2'd1, 8'h07, 8'h00, 8'h00},
    '{sed_pkg::CH_BSLASH, 1'b1, 1'b1, 2'd1, 8'h5C, 8'h00, 8'h00},
    '{sed_pkg::CH_BSLASH, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{sed_pkg::CH_X,      1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{"A",                1'b1, 1'b1, 2'd2, 8'h5C, 8'h41, 8'h00}
  };

  logic clk;
  logic rst_n;

  sed_in_if  in_ch ();
  sed_out_if out_ch ();

  string_escape_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // row carried alongside the transaction, sampled at acceptance
  dir_row_t   cur_row;

  dec_phase_t dec_phase = S_PLAIN;
  logic [7:0] acc_val   = 8'h00;
  logic [7:0] held_ch   = 8'h00;
  logic [7:0] dec_buf [3];
  int         dec_n;

  dec_out_t   exp_q [$];
  dec_out_t   got;
  dec_out_t   want;
  logic [8:0] lit_q [$];

  int         err_cnt  = 0;
  bit         quiet    = 1'b0;
  bit         hold_req = 1'b0;
  int         rx_rate  = 10;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_error(input string what);
    err_cnt++;
    if (err_cnt <= 50) $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic int esc_letter(input logic [7:0] c);
    for (int i = 0; i < 11; i++) begin
      if (c == ESC_LETTERS[i]) begin
        case (i)
          0: return 8'h0A;
          1: return 8'h09;
          2: return 8'h0D;
          3: return 8'h08;
          4: return 8'h0C;
          5: return 8'h0B;
          6: return 8'h07;
          default: return int'(c);
        endcase
      end
    end
    return -1;
  endfunction

  function automatic bit is_octal(input logic [7:0] c);
    return (c >= "0") && (c <= "7");
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 97 + 10;
    if (c >= "A" && c <= "F") return int'(c) - 65 + 10;
    return -1;
  endfunction

  function automatic void emit(input int v);
    if (dec_n < 3) begin
      dec_buf[dec_n] = v[7:0];
      dec_n++;
    end
  endfunction

  function automatic void take_plain(input logic [7:0] b, input logic eol);
    if (b == sed_pkg::CH_BSLASH && !eol) dec_phase = S_ESC;
    else emit(int'(b));
  endfunction

  function automatic void decode_step(input logic [7:0] b, input logic eol);
    dec_phase_t cur;
    int         code;
    int         v;
    int         nib;
    cur       = dec_phase;
    dec_n     = 0;
    dec_phase = S_PLAIN;
    code      = esc_letter(b);
    nib       = hex_val(b);
    v         = int'(acc_val) * 8 + int'(b) - 48;
    case (cur)
      S_ESC: begin
        if (code >= 0) emit(code);
        else if (is_octal(b)) begin
          if (eol) emit(int'(b) - 48);
          else begin
            acc_val   = b - 8'h30;
            dec_phase = S_OCT2;
          end
        end else if (b == sed_pkg::CH_X && !eol) dec_phase = S_HEX1;
        else emit(int'(sed_pkg::CH_BSLASH));
      end
      S_OCT2: begin
        if (is_octal(b)) begin
          if (eol) emit(v);
          else begin
            acc_val   = v[7:0];
            held_ch   = b;
            dec_phase = S_OCT3;
          end
        end else begin
          emit(int'(acc_val));
          take_plain(b, eol);
        end
      end
      S_OCT3: begin
        if (is_octal(b)) begin
          if (v <= 255) emit(v);
          else begin
            emit(int'(sed_pkg::CH_BSLASH));
            emit(int'(held_ch));
            emit(int'(b));
          end
        end else begin
          emit(int'(acc_val));
          take_plain(b, eol);
        end
      end
      S_HEX1: begin
        if (nib >= 0 && !eol) begin
          acc_val   = nib[7:0];
          held_ch   = b;
          dec_phase = S_HEX2;
        end else begin
          emit(int'(sed_pkg::CH_BSLASH));
          take_plain(b, eol);
        end
      end
      S_HEX2: begin
        if (nib >= 0) emit(int'(acc_val) * 16 + nib);
        else begin
          emit(int'(sed_pkg::CH_BSLASH));
          emit(int'(held_ch));
          take_plain(b, eol);
        end
      end
      default: take_plain(b, eol);
    endcase
    if (eol) dec_phase = S_PLAIN;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_step(in_ch.in_byte, in_ch.end_of_literal);
        if (cur_row.typed) begin
          dec_n      = int'(cur_row.n);
          dec_buf[0] = cur_row.r0;
          dec_buf[1] = cur_row.r1;
          dec_buf[2] = cur_row.r2;
        end
        for (int k = 0; k < dec_n; k++)
          exp_q.push_back('{dec_buf[k], k == dec_n - 1,
                            (k == dec_n - 1) && in_ch.end_of_literal});
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_byte, out_ch.run_last, out_ch.string_done};
        if (exp_q.size() == 0) begin
          report_error($sformatf("unexpected result byte %02h", got.data));
        end else begin
          want = exp_q.pop_front();
          if (got.data != want.data)
            report_error($sformatf("out_byte %02h, expected %02h", got.data, want.data));
          if (got.last != want.last)
            report_error($sformatf("run_last %0b, expected %0b", got.last, want.last));
          if (got.done != want.done)
            report_error($sformatf("string_done %0b, expected %0b", got.done, want.done));
        end
      end
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int hold_cnt;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 49) == 0) begin
        case ($urandom_range(0, 2))
          0: rx_rate = 0;
          1: rx_rate = 10;
          default: rx_rate = 30;
        endcase
      end
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYC) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < rx_rate) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input dir_row_t row);
    in_ch.valid          <= 1'b1;
    in_ch.in_byte        <= row.b;
    in_ch.end_of_literal <= row.eol;
    cur_row              <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_hex();
    int idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) return 8'(idx + 48);
    if (idx < 16) return 8'(idx + 97 - 10);
    return 8'(idx + 65 - 16);
  endfunction

  // one literal body of random escapes and plain bytes, end flag on the last byte
  task automatic build_literal();
    int         ntok;
    int         ndig;
    int         cut;
    logic [7:0] d;
    lit_q.delete();
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        3: begin
          lit_q.push_back({1'b0, sed_pkg::CH_BSLASH});
          lit_q.push_back({1'b0, ESC_LETTERS[$urandom_range(0, 10)]});
        end
        4: begin
          lit_q.push_back({1'b0, sed_pkg::CH_BSLASH});
          ndig = $urandom_range(1, 3);
          repeat (ndig) begin
            d = 8'h30 + 8'($urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0) d = 8'h38 + 8'($urandom_range(0, 1));
            lit_q.push_back({1'b0, d});
          end
        end
        5: begin
          lit_q.push_back({1'b0, sed_pkg::CH_BSLASH});
          lit_q.push_back({1'b0, sed_pkg::CH_X});
          repeat (2) begin
            d = pick_hex();
            if ($urandom_range(0, 5) == 0) d = 8'($urandom_range(0, 255));
            lit_q.push_back({1'b0, d});
          end
        end
        6: begin
          lit_q.push_back({1'b0, sed_pkg::CH_BSLASH});
          case ($urandom_range(0, 2))
            0: lit_q.push_back({1'b0, 8'h75});
            1: lit_q.push_back({1'b0, 8'h55});
            default: lit_q.push_back({1'b0, 8'($urandom_range(0, 255))});
          endcase
        end
        7: begin
          lit_q.push_back({1'b0, sed_pkg::CH_BSLASH});
          lit_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
        8, 9: lit_q.push_back({1'b0, 8'($urandom_range(32, 126))});
        default: lit_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      endcase
    end
    if ($urandom_range(0, 3) == 0 && lit_q.size() > 1) begin
      cut = $urandom_range(1, 2);
      while (cut > 0 && lit_q.size() > 1) begin
        void'(lit_q.pop_back());
        cut--;
      end
    end
    lit_q[lit_q.size() - 1][8] = 1'b1;
  endtask

  initial begin
    dir_row_t row;
    int       sent;
    bit       gaps_on;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.in_byte        = 8'h00;
    in_ch.end_of_literal = 1'b0;
    cur_row              = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) send_byte(DIR_TAB[i]);

    sent = 0;
    while (sent < N_RANDOM) begin
      build_literal();
      gaps_on = ($urandom_range(0, 2) != 0);
      foreach (lit_q[i]) begin
        if (sent == 90) hold_req = 1'b1;
        if (sent == 180) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (exp_q.size() != 0) @(posedge clk);
        end
        if (sent >= 220) quiet = 1'b1;
        row       = '0;
        row.b     = lit_q[i][7:0];
        row.eol   = lit_q[i][8];
        send_byte(row);
        sent++;
        if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0 && exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
sv/sed_pkg.sv
sv/sed_ifs.sv
sv/sed_front.sv
sv/sed_queue.sv
sv/sed_back.sv
sv/string_escape_decoder.sv
tb/testbench.sv
